FILE: sv/lpc_pkg.sv
// shared constants and codes for the light panel calibrator control
`timescale 1ns / 1ps
`default_nettype none

package lpc_pkg;

    // payload widths
    localparam int STEP_W     = 16;
    localparam int DUTY_OUT_W = 8;
    localparam int CMD_W      = 3;
    localparam int MODE_W     = 2;
    localparam int ACC_W      = 2 * STEP_W;
    localparam int CNT_W      = $clog2(STEP_W);

    // pwm resolution default, legal range 8 to 16
    localparam int PWM_BITS_DEF = 8;

    // apb side
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 4;

    // register word index
    localparam logic [1:0] REG_MAX_BRIGHTNESS  = 2'd0;
    localparam logic [1:0] REG_STABILIZE_TICKS = 2'd1;
    localparam logic [1:0] REG_AUTO_RESTORE    = 2'd2;

    // register reset values
    localparam logic [STEP_W-1:0] MAX_BRIGHTNESS_RST  = 16'd255;
    localparam logic [STEP_W-1:0] STABILIZE_TICKS_RST = 16'd1000;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SET_LEVEL      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_OFF            = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SAVE_BROADBAND = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SAVE_NARROW    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESTORE        = 3'd4;
    localparam logic [CMD_W-1:0] CMD_TICK           = 3'd5;

    // readiness codes
    localparam logic [MODE_W-1:0] MODE_OFF       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NOT_READY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READY     = 2'd2;

endpackage

`default_nettype wire

FILE: sv/lpc_cmd_if.sv
// command channel: command code and requested brightness step
`timescale 1ns / 1ps
`default_nettype none

interface lpc_cmd_if;
    import lpc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [STEP_W-1:0] level_step;

    modport source (output valid, output cmd, output level_step, input ready);
    modport sink   (input valid, input cmd, input level_step, output ready);
endinterface

`default_nettype wire

FILE: sv/lpc_rpt_if.sv
// report channel: panel drive, readiness and steps after each command
`timescale 1ns / 1ps
`default_nettype none

interface lpc_rpt_if;
    import lpc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DUTY_OUT_W-1:0] pwm_duty;
    logic                  relay_on;
    logic [MODE_W-1:0]     ready_state;
    logic [STEP_W-1:0]     current_step;
    logic [STEP_W-1:0]     broadband_step;
    logic [STEP_W-1:0]     narrowband_step;

    modport source (output valid, output pwm_duty, output relay_on, output ready_state,
                    output current_step, output broadband_step, output narrowband_step,
                    input ready);
    modport sink   (input valid, input pwm_duty, input relay_on, input ready_state,
                    input current_step, input broadband_step, input narrowband_step,
                    output ready);
endinterface

`default_nettype wire

FILE: sv/light_panel_calibrator_control.sv
// Light panel calibrator control: takes one command beat at a time and returns one report
// beat per command. Every step/duty conversion runs on a single shared bit-serial unit that
// computes a*b/c as a shift-add multiply followed by a restoring divide. A command runs
// k conversions: k = 3 for off, save, tick, disabled restore and unused codes (current,
// broadband and narrowband steps), k = 4 for set level, k = 5 for an enabled restore, and
// k = 0 whenever max_brightness is 0 (all steps report 0). A new command is taken as soon
// as the unit is free, even while the previous report still waits in the output register.
// Registers sit on an APB port at byte addresses 0 (max_brightness), 4 (stabilize_ticks)
// and 8 (auto_restore) and are to be written only while no command is in flight.
`timescale 1ns / 1ps
`default_nettype none

module light_panel_calibrator_control #(
    parameter int PWM_BITS = lpc_pkg::PWM_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [lpc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [lpc_pkg::PDATA_W-1:0]  pwdata,
    output logic      [lpc_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    lpc_cmd_if.sink                           command,
    lpc_rpt_if.source                         report
);
    import lpc_pkg::*;

    localparam logic [STEP_W-1:0] PWM_MAX = STEP_W'((1 << PWM_BITS) - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    typedef enum logic [2:0] {
        OP_RESTORE_STEP,
        OP_LEVEL,
        OP_CUR,
        OP_BROAD,
        OP_NARROW
    } op_t;

    // configuration
    logic [STEP_W-1:0] max_bright_reg;
    logic [STEP_W-1:0] stab_ticks_reg;
    logic              auto_restore_reg;

    // panel state
    state_t              state_reg,       state_next;
    op_t                 op_reg,          op_next;
    logic [PWM_BITS-1:0] duty_reg,        duty_next;
    logic [MODE_W-1:0]   mode_reg,        mode_next;
    logic [STEP_W-1:0]   elapsed_reg,     elapsed_next;
    logic [PWM_BITS-1:0] last_stable_reg, last_stable_next;
    logic [PWM_BITS-1:0] broad_duty_reg,  broad_duty_next;
    logic [PWM_BITS-1:0] narrow_duty_reg, narrow_duty_next;
    logic                relay_reg,       relay_next;

    // serial mul/div unit
    logic [ACC_W-1:0]  acc_reg,    acc_next;
    logic [STEP_W-1:0] mcand_reg,  mcand_next;
    logic [STEP_W-1:0] dvs_reg,    dvs_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic [STEP_W-1:0] cur_step_reg,    cur_step_next;
    logic [STEP_W-1:0] broad_step_reg,  broad_step_next;

    // report register
    logic                  out_valid_reg, out_valid_next;
    logic [DUTY_OUT_W-1:0] out_duty_reg;
    logic                  out_relay_reg;
    logic [MODE_W-1:0]     out_mode_reg;
    logic [STEP_W-1:0]     out_cur_reg;
    logic [STEP_W-1:0]     out_broad_reg;
    logic [STEP_W-1:0]     out_narrow_reg;
    logic                  out_load;

    logic              cfg_wr;
    logic [STEP_W:0]   mul_sum;
    logic [ACC_W-1:0]  mul_acc;
    logic [ACC_W:0]    div_shift;
    logic [STEP_W+1:0] div_diff;
    logic              div_ge;
    logic [STEP_W-1:0] div_rem;
    logic [ACC_W-1:0]  div_acc;
    logic [STEP_W-1:0] quot;
    logic [STEP_W-1:0] step_clamp;
    logic [STEP_W-1:0] elapsed_inc;
    logic              launch;
    op_t               launch_op;
    logic [STEP_W-1:0] launch_a;
    logic [STEP_W-1:0] launch_b;
    logic [STEP_W-1:0] launch_c;
    logic              conv_start;
    logic [STEP_W-1:0] conv_b;

    // ---------------------------------------------------------------- apb
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[3:2])
            REG_MAX_BRIGHTNESS:  prdata = PDATA_W'(max_bright_reg);
            REG_STABILIZE_TICKS: prdata = PDATA_W'(stab_ticks_reg);
            REG_AUTO_RESTORE:    prdata = PDATA_W'(auto_restore_reg);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bright_reg   <= MAX_BRIGHTNESS_RST;
            stab_ticks_reg   <= STABILIZE_TICKS_RST;
            auto_restore_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_MAX_BRIGHTNESS:  max_bright_reg   <= pwdata[STEP_W-1:0];
                REG_STABILIZE_TICKS: stab_ticks_reg   <= pwdata[STEP_W-1:0];
                REG_AUTO_RESTORE:    auto_restore_reg <= pwdata[0];
                default:             ;
            endcase
        end
    end

    // ---------------------------------------------------------------- datapath steps
    // multiply: add multiplicand into the high half when the low bit is set, shift right
    assign mul_sum = {1'b0, acc_reg[ACC_W-1:STEP_W]}
                     + (acc_reg[0] ? {1'b0, mcand_reg} : '0);
    assign mul_acc = {mul_sum, acc_reg[STEP_W-1:1]};

    // restoring divide: high half is the remainder, quotient bits enter at the bottom
    assign div_shift = {acc_reg, 1'b0};
    assign div_diff  = {1'b0, div_shift[ACC_W:STEP_W]} - {2'b00, dvs_reg};
    assign div_ge    = ~div_diff[STEP_W+1];
    assign div_rem   = div_ge ? div_diff[STEP_W-1:0] : div_shift[ACC_W-1:STEP_W];
    assign div_acc   = {div_rem, div_shift[STEP_W-1:1], div_ge};
    assign quot      = div_acc[STEP_W-1:0];

    assign step_clamp  = (command.level_step > max_bright_reg) ? max_bright_reg
                                                               : command.level_step;
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;

    assign command.ready = (state_reg == S_IDLE);
    assign out_load      = (state_reg == S_OUT) && (!out_valid_reg || report.ready);

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        duty_next        = duty_reg;
        mode_next        = mode_reg;
        elapsed_next     = elapsed_reg;
        last_stable_next = last_stable_reg;
        broad_duty_next  = broad_duty_reg;
        narrow_duty_next = narrow_duty_reg;
        relay_next       = relay_reg;
        acc_next         = acc_reg;
        mcand_next       = mcand_reg;
        dvs_next         = dvs_reg;
        cnt_next         = cnt_reg;
        cur_step_next    = cur_step_reg;
        broad_step_next  = broad_step_reg;
        out_valid_next   = out_valid_reg;
        launch           = 1'b0;
        launch_op        = OP_CUR;
        launch_a         = max_bright_reg;
        launch_b         = '0;
        launch_c         = PWM_MAX;
        conv_start       = 1'b0;
        conv_b           = '0;

        if (out_valid_reg && report.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (command.valid)
                begin
                    conv_start = 1'b1;
                    conv_b     = STEP_W'(duty_reg);
                    case (command.cmd)
                        CMD_SET_LEVEL:
                        begin
                            mode_next    = MODE_NOT_READY;
                            relay_next   = 1'b1;
                            elapsed_next = '0;
                            if (max_bright_reg == '0)
                            begin
                                duty_next = '0;
                                conv_b    = '0;
                            end
                            else
                            begin
                                conv_start = 1'b0;
                                launch     = 1'b1;
                                launch_op  = OP_LEVEL;
                                launch_a   = step_clamp;
                                launch_b   = PWM_MAX;
                                launch_c   = max_bright_reg;
                            end
                        end
                        CMD_OFF:
                        begin
                            duty_next  = '0;
                            mode_next  = MODE_OFF;
                            relay_next = 1'b0;
                            conv_b     = '0;
                        end
                        CMD_SAVE_BROADBAND:
                        begin
                            broad_duty_next = duty_reg;
                        end
                        CMD_SAVE_NARROW:
                        begin
                            narrow_duty_next = duty_reg;
                        end
                        CMD_RESTORE:
                        begin
                            if (auto_restore_reg)
                            begin
                                mode_next    = MODE_NOT_READY;
                                relay_next   = 1'b1;
                                elapsed_next = '0;
                                if (max_bright_reg == '0)
                                begin
                                    duty_next = '0;
                                    conv_b    = '0;
                                end
                                else
                                begin
                                    conv_start = 1'b0;
                                    launch     = 1'b1;
                                    launch_op  = OP_RESTORE_STEP;
                                    launch_b   = STEP_W'(last_stable_reg);
                                end
                            end
                        end
                        CMD_TICK:
                        begin
                            if (mode_reg == MODE_NOT_READY)
                            begin
                                elapsed_next = elapsed_inc;
                                if (elapsed_inc >= stab_ticks_reg)
                                begin
                                    mode_next        = MODE_READY;
                                    last_stable_next = duty_reg;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                acc_next = mul_acc;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEP_W - 1))
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                acc_next = div_acc;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEP_W - 1))
                begin
                    case (op_reg)
                        OP_RESTORE_STEP:
                        begin
                            launch    = 1'b1;
                            launch_op = OP_LEVEL;
                            launch_a  = (quot > max_bright_reg) ? max_bright_reg : quot;
                            launch_b  = PWM_MAX;
                            launch_c  = max_bright_reg;
                        end
                        OP_LEVEL:
                        begin
                            duty_next  = quot[PWM_BITS-1:0];
                            conv_start = 1'b1;
                            conv_b     = STEP_W'(quot[PWM_BITS-1:0]);
                        end
                        OP_CUR:
                        begin
                            cur_step_next = quot;
                            launch        = 1'b1;
                            launch_op     = OP_BROAD;
                            launch_b      = STEP_W'(broad_duty_reg);
                        end
                        OP_BROAD:
                        begin
                            broad_step_next = quot;
                            launch          = 1'b1;
                            launch_op       = OP_NARROW;
                            launch_b        = STEP_W'(narrow_duty_reg);
                        end
                        default:
                        begin
                            // narrowband result stays in the accumulator low half
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // the three report steps, all zero when max brightness is zero
        if (conv_start)
        begin
            if (max_bright_reg == '0)
            begin
                cur_step_next   = '0;
                broad_step_next = '0;
                acc_next        = '0;
                state_next      = S_OUT;
            end
            else
            begin
                launch    = 1'b1;
                launch_op = OP_CUR;
                launch_a  = max_bright_reg;
                launch_b  = conv_b;
                launch_c  = PWM_MAX;
            end
        end

        if (launch)
        begin
            state_next = S_MUL;
            op_next    = launch_op;
            mcand_next = launch_a;
            dvs_next   = launch_c;
            acc_next   = {{STEP_W{1'b0}}, launch_b};
            cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_CUR;
            duty_reg        <= '0;
            mode_reg        <= MODE_OFF;
            elapsed_reg     <= '0;
            last_stable_reg <= PWM_MAX[PWM_BITS-1:0];
            broad_duty_reg  <= '0;
            narrow_duty_reg <= '0;
            relay_reg       <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            duty_reg        <= duty_next;
            mode_reg        <= mode_next;
            elapsed_reg     <= elapsed_next;
            last_stable_reg <= last_stable_next;
            broad_duty_reg  <= broad_duty_next;
            narrow_duty_reg <= narrow_duty_next;
            relay_reg       <= relay_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg        <= acc_next;
        mcand_reg      <= mcand_next;
        dvs_reg        <= dvs_next;
        cur_step_reg   <= cur_step_next;
        broad_step_reg <= broad_step_next;
        if (out_load)
        begin
            out_duty_reg   <= duty_reg[DUTY_OUT_W-1:0];
            out_relay_reg  <= relay_reg;
            out_mode_reg   <= mode_reg;
            out_cur_reg    <= cur_step_reg;
            out_broad_reg  <= broad_step_reg;
            out_narrow_reg <= acc_reg[STEP_W-1:0];
        end
    end

    assign report.valid           = out_valid_reg;
    assign report.pwm_duty        = out_duty_reg;
    assign report.relay_on        = out_relay_reg;
    assign report.ready_state     = out_mode_reg;
    assign report.current_step    = out_cur_reg;
    assign report.broadband_step  = out_broad_reg;
    assign report.narrowband_step = out_narrow_reg;

    // ---------------------------------------------------------------- checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (command.valid && command.ready) |=> (state_reg != S_IDLE))
        else $error("command beat accepted but sequencer stayed idle");

    a_relay_follows_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (relay_reg == 1'b0) == (mode_reg == MODE_OFF))
        else $error("relay state disagrees with readiness state");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (acc_reg[ACC_W-1:STEP_W] < dvs_reg))
        else $error("divider remainder not below divisor");

    a_report_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !out_valid_reg) |=> out_valid_reg)
        else $error("free report register not loaded");

endmodule

`default_nettype wire

FILE: sim/tb.sv
// testbench for the light panel calibrator control: directed table, random phases, report checks
`timescale 1ns / 1ps

module tb;
    import lpc_pkg::*;

    localparam int PWM_BITS = PWM_BITS_DEF;
    localparam logic [63:0] PWM_FULL = (64'd1 << PWM_BITS) - 64'd1;

    // command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int HOLD_CYCLES     = 900;
    localparam int DRAIN_CYCLES    = 200;

    typedef struct packed {
        logic [DUTY_OUT_W-1:0] duty;
        logic                  relay;
        logic [MODE_W-1:0]     mode;
        logic [STEP_W-1:0]     cur_step;
        logic [STEP_W-1:0]     bb_step;
        logic [STEP_W-1:0]     nb_step;
    } report_t;

    typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [CMD_W-1:0]  cmd;
        logic [STEP_W-1:0] value;
        logic [1:0]        reg_idx;
        bit                typed;
        report_t           want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    wire  [PDATA_W-1:0]   prdata;
    wire                  pready;

    lpc_cmd_if cmd_ch ();
    lpc_rpt_if rpt_ch ();

    light_panel_calibrator_control DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .command (cmd_ch),
        .report  (rpt_ch)
    );

    // predictor configuration and state
    logic [STEP_W-1:0]   cfg_max_bright;
    logic [STEP_W-1:0]   cfg_stab_ticks;
    logic                cfg_auto_restore;
    logic [PWM_BITS-1:0] pan_duty;
    logic [MODE_W-1:0]   pan_mode;
    logic [STEP_W-1:0]   tick_count;
    logic [PWM_BITS-1:0] stable_duty;
    logic [PWM_BITS-1:0] bb_duty;
    logic [PWM_BITS-1:0] nb_duty;
    logic                relay_state;

    report_t   pending_reports[$];
    stim_row_t directed_rows[$];
    int        mismatch_count = 0;
    int        burst_left = 0;
    int        holds_requested = 0;
    int        holds_done = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("tb failed");
        $finish;
    end

    function automatic void reset_panel_model();
        cfg_max_bright   = MAX_BRIGHTNESS_RST;
        cfg_stab_ticks   = STABILIZE_TICKS_RST;
        cfg_auto_restore = 1'b0;
        pan_duty         = '0;
        pan_mode         = MODE_OFF;
        tick_count       = '0;
        stable_duty      = PWM_BITS'(PWM_FULL);
        bb_duty          = '0;
        nb_duty          = '0;
        relay_state      = 1'b0;
    endfunction

    function automatic logic [STEP_W-1:0] duty_as_step(input logic [PWM_BITS-1:0] d);
        logic [63:0] prod;
        if (cfg_max_bright == '0)
            return '0;
        prod = 64'(d) * 64'(cfg_max_bright);
        return STEP_W'(prod / PWM_FULL);
    endfunction

    function automatic void apply_step(input logic [STEP_W-1:0] s);
        logic [STEP_W-1:0] clamped;
        logic [63:0]       prod;
        clamped = (s > cfg_max_bright) ? cfg_max_bright : s;
        if (cfg_max_bright == '0)
            pan_duty = '0;
        else
        begin
            prod     = 64'(clamped) * PWM_FULL;
            pan_duty = PWM_BITS'(prod / 64'(cfg_max_bright));
        end
        pan_mode    = MODE_NOT_READY;
        relay_state = 1'b1;
        tick_count  = '0;
    endfunction

    function automatic report_t predict_report(input logic [CMD_W-1:0] c,
                                               input logic [STEP_W-1:0] lvl);
        report_t r;
        case (c)
            CMD_SET_LEVEL: apply_step(lvl);
            CMD_OFF:
            begin
                pan_duty    = '0;
                pan_mode    = MODE_OFF;
                relay_state = 1'b0;
            end
            CMD_SAVE_BROADBAND: bb_duty = pan_duty;
            CMD_SAVE_NARROW:    nb_duty = pan_duty;
            CMD_RESTORE:
                if (cfg_auto_restore)
                    apply_step(duty_as_step(stable_duty));
            CMD_TICK:
                if (pan_mode == MODE_NOT_READY)
                begin
                    // counter saturates instead of wrapping
                    if (tick_count != '1)
                        tick_count = tick_count + 1'b1;
                    if (tick_count >= cfg_stab_ticks)
                    begin
                        pan_mode    = MODE_READY;
                        stable_duty = pan_duty;
                    end
                end
            default: ;
        endcase
        r.duty     = DUTY_OUT_W'(pan_duty);
        r.relay    = relay_state;
        r.mode     = pan_mode;
        r.cur_step = duty_as_step(pan_duty);
        r.bb_step  = duty_as_step(bb_duty);
        r.nb_step  = duty_as_step(nb_duty);
        return r;
    endfunction

    task automatic add_beat(input logic [CMD_W-1:0] c, input logic [STEP_W-1:0] lvl);
        stim_row_t row;
        row.kind    = ROW_BEAT;
        row.cmd     = c;
        row.value   = lvl;
        row.reg_idx = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_typed(input logic [CMD_W-1:0] c, input logic [STEP_W-1:0] lvl,
                             input logic [DUTY_OUT_W-1:0] duty, input logic relay,
                             input logic [MODE_W-1:0] mode, input logic [STEP_W-1:0] cur,
                             input logic [STEP_W-1:0] bb, input logic [STEP_W-1:0] nb);
        stim_row_t row;
        row.kind          = ROW_BEAT;
        row.cmd           = c;
        row.value         = lvl;
        row.reg_idx       = '0;
        row.typed         = 1'b1;
        row.want.duty     = duty;
        row.want.relay    = relay;
        row.want.mode     = mode;
        row.want.cur_step = cur;
        row.want.bb_step  = bb;
        row.want.nb_step  = nb;
        directed_rows.push_back(row);
    endtask

    task automatic add_reg(input logic [1:0] idx, input logic [STEP_W-1:0] val);
        stim_row_t row;
        row.kind    = ROW_REG;
        row.cmd     = '0;
        row.value   = val;
        row.reg_idx = idx;
        row.typed   = 1'b0;
        row.want    = '0;
        directed_rows.push_back(row);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [STEP_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MAX_BRIGHTNESS:  cfg_max_bright   = val;
            REG_STABILIZE_TICKS: cfg_stab_ticks   = val;
            REG_AUTO_RESTORE:    cfg_auto_restore = val[0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // valid drops at the accepting edge whenever a gap or the end of a run follows
    task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [STEP_W-1:0] lvl,
                            input bit last_in_run, input bit use_typed,
                            input report_t typed_want);
        report_t want;
        int      gap;
        cmd_ch.valid      <= 1'b1;
        cmd_ch.cmd        <= c;
        cmd_ch.level_step <= lvl;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        want = predict_report(c, lvl);
        if (use_typed)
            want = typed_want;
        pending_reports.push_back(want);
        if (burst_left > 0)
            burst_left--;
        if (last_in_run || burst_left == 0)
        begin
            cmd_ch.valid <= 1'b0;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                if (!last_in_run)
                begin
                    case ($urandom_range(0, 9))
                        0:       gap = $urandom_range(41, 250);
                        1, 2, 3: gap = $urandom_range(4, 40);
                        default: gap = $urandom_range(1, 3);
                    endcase
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    task automatic rand_item(output logic [CMD_W-1:0] c, output logic [STEP_W-1:0] lvl);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            c = CMD_TICK;
        else if (pick < 60)
            c = CMD_SET_LEVEL;
        else if (pick < 68)
            c = CMD_SAVE_BROADBAND;
        else if (pick < 76)
            c = CMD_SAVE_NARROW;
        else if (pick < 88)
            c = CMD_RESTORE;
        else if (pick < 96)
            c = CMD_OFF;
        else if (pick < 98)
            c = CMD_SPARE_6;
        else
            c = CMD_SPARE_7;
        case ($urandom_range(0, 4))
            0:       lvl = STEP_W'($urandom);
            1:       lvl = STEP_W'($urandom_range(0, cfg_max_bright));
            2:       lvl = cfg_max_bright;
            3:       lvl = '1;
            default: lvl = cfg_max_bright + STEP_W'($urandom_range(1, 8));
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t report %s: expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // report sink, with a long hold-off whenever one is requested
    initial
    begin
        int span_left;
        int stall_mode;
        span_left     = 0;
        stall_mode    = 0;
        rpt_ch.ready  = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_requested)
            begin
                rpt_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else
            begin
                if (span_left == 0)
                begin
                    span_left  = $urandom_range(1, 200);
                    stall_mode = $urandom_range(0, 3);
                end
                span_left--;
                case (stall_mode)
                    0:       rpt_ch.ready <= 1'b1;
                    1:       rpt_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       rpt_ch.ready <= $urandom_range(0, 1);
                    default: rpt_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        report_t want;
        if (rst_n && rpt_ch.valid && rpt_ch.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                mismatch_count++;
                $display("%0t report beat with none expected: expected nothing, got duty %0d",
                         $time, rpt_ch.pwm_duty);
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("pwm_duty", want.duty, rpt_ch.pwm_duty);
                check_field("relay_on", want.relay, rpt_ch.relay_on);
                check_field("ready_state", want.mode, rpt_ch.ready_state);
                check_field("current_step", want.cur_step, rpt_ch.current_step);
                check_field("broadband_step", want.bb_step, rpt_ch.broadband_step);
                check_field("narrowband_step", want.nb_step, rpt_ch.narrowband_step);
            end
        end
    end

    initial
    begin
        logic [CMD_W-1:0]  c;
        logic [STEP_W-1:0] lvl;
        bit                last;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.cmd        = CMD_TICK;
        cmd_ch.level_step = '0;
        reset_panel_model();
        burst_left = $urandom_range(1, 12);

        // reset values: max 255, stabilize 1000, restore off
        add_typed(CMD_TICK, 16'h0000, 8'd0, 1'b0, MODE_OFF, 16'd0, 16'd0, 16'd0);
        add_typed(CMD_SPARE_6, 16'hFFFF, 8'd0, 1'b0, MODE_OFF, 16'd0, 16'd0, 16'd0);
        add_typed(CMD_SPARE_7, 16'h0000, 8'd0, 1'b0, MODE_OFF, 16'd0, 16'd0, 16'd0);
        add_typed(CMD_RESTORE, 16'h1234, 8'd0, 1'b0, MODE_OFF, 16'd0, 16'd0, 16'd0);
        add_typed(CMD_SET_LEVEL, 16'hFFFF, 8'd255, 1'b1, MODE_NOT_READY,
                  16'd255, 16'd0, 16'd0);
        add_typed(CMD_SAVE_BROADBAND, 16'h0000, 8'd255, 1'b1, MODE_NOT_READY,
                  16'd255, 16'd255, 16'd0);
        add_typed(CMD_SET_LEVEL, 16'h0000, 8'd0, 1'b1, MODE_NOT_READY,
                  16'd0, 16'd255, 16'd0);
        add_typed(CMD_SAVE_NARROW, 16'h0000, 8'd0, 1'b1, MODE_NOT_READY,
                  16'd0, 16'd255, 16'd0);
        add_beat(CMD_SET_LEVEL, 16'd128);
        add_typed(CMD_OFF, 16'hFFFF, 8'd0, 1'b0, MODE_OFF, 16'd0, 16'd255, 16'd0);
        add_reg(REG_STABILIZE_TICKS, 16'd0);
        add_beat(CMD_SET_LEVEL, 16'd100);
        add_beat(CMD_TICK, 16'h0000);
        add_beat(CMD_TICK, 16'hFFFF);
        add_reg(REG_AUTO_RESTORE, 16'd1);
        add_beat(CMD_SET_LEVEL, 16'h5555);
        add_beat(CMD_RESTORE, 16'h0000);
        // zero max brightness: duty and every step read zero
        add_reg(REG_MAX_BRIGHTNESS, 16'd0);
        add_typed(CMD_SET_LEVEL, 16'hAAAA, 8'd0, 1'b1, MODE_NOT_READY,
                  16'd0, 16'd0, 16'd0);
        add_typed(CMD_RESTORE, 16'h0000, 8'd0, 1'b1, MODE_NOT_READY, 16'd0, 16'd0, 16'd0);
        add_typed(CMD_TICK, 16'h0000, 8'd0, 1'b1, MODE_READY, 16'd0, 16'd0, 16'd0);
        add_reg(REG_MAX_BRIGHTNESS, 16'hFFFF);
        add_reg(REG_STABILIZE_TICKS, 16'd3);
        add_beat(CMD_SET_LEVEL, 16'd1);
        add_typed(CMD_SET_LEVEL, 16'hFFFF, 8'd255, 1'b1, MODE_NOT_READY,
                  16'hFFFF, 16'hFFFF, 16'd0);
        add_beat(CMD_SAVE_NARROW, 16'h0000);
        add_beat(CMD_TICK, 16'h0000);
        add_beat(CMD_TICK, 16'h0000);
        add_beat(CMD_TICK, 16'h0000);
        add_beat(CMD_OFF, 16'h0000);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        for (int i = 0; i < directed_rows.size(); i++)
        begin
            if (directed_rows[i].kind == ROW_REG)
            begin
                wait_idle();
                reg_write(directed_rows[i].reg_idx, directed_rows[i].value);
            end
            else
            begin
                last = (i == directed_rows.size() - 1) || (directed_rows[i + 1].kind == ROW_REG);
                send_cmd(directed_rows[i].cmd, directed_rows[i].value, last,
                         directed_rows[i].typed, directed_rows[i].want);
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0:
                begin
                    reg_write(REG_MAX_BRIGHTNESS, 16'd255);
                    reg_write(REG_STABILIZE_TICKS, 16'd4);
                    reg_write(REG_AUTO_RESTORE, 16'd1);
                end
                1:
                begin
                    reg_write(REG_MAX_BRIGHTNESS, 16'd1);
                    reg_write(REG_STABILIZE_TICKS, 16'd0);
                    reg_write(REG_AUTO_RESTORE, 16'd1);
                end
                2:
                begin
                    reg_write(REG_MAX_BRIGHTNESS, 16'hFFFF);
                    reg_write(REG_STABILIZE_TICKS, 16'd2);
                    reg_write(REG_AUTO_RESTORE, 16'd1);
                end
                3:
                begin
                    reg_write(REG_MAX_BRIGHTNESS, 16'd0);
                    reg_write(REG_STABILIZE_TICKS, 16'd1);
                    reg_write(REG_AUTO_RESTORE, 16'd1);
                end
                4:
                begin
                    // longest stabilize time, ready is never reached here
                    reg_write(REG_MAX_BRIGHTNESS, 16'd1000);
                    reg_write(REG_STABILIZE_TICKS, 16'hFFFF);
                    reg_write(REG_AUTO_RESTORE, 16'd1);
                end
                5:
                begin
                    reg_write(REG_MAX_BRIGHTNESS, 16'd2);
                    reg_write(REG_STABILIZE_TICKS, 16'd12);
                    reg_write(REG_AUTO_RESTORE, 16'd0);
                end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0:       lvl = STEP_W'($urandom);
                        1:       lvl = 16'd256;
                        default: lvl = STEP_W'($urandom_range(1, 300));
                    endcase
                    reg_write(REG_MAX_BRIGHTNESS, lvl);
                    reg_write(REG_STABILIZE_TICKS, STEP_W'($urandom_range(0, 25)));
                    reg_write(REG_AUTO_RESTORE, STEP_W'($urandom_range(0, 1)));
                end
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (k == 40 && (ph == 1 || ph == 6))
                    holds_requested++;
                rand_item(c, lvl);
                send_cmd(c, lvl, k == ITEMS_PER_PHASE - 1, 1'b0, '0);
            end
        end

        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
